FILE: rtl/segment_allocator_fit_policies_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the segment allocator
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_ALLOCATOR_FIT_POLICIES_MACROS_SVH
`define SEGMENT_ALLOCATOR_FIT_POLICIES_MACROS_SVH

// prop holds at every clock edge outside reset
`define SALFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// ante at one edge implies cons at the next
`define SALFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/salfp_pkg.sv
// ---------------------------------------------------------------------------
// salfp_pkg
// Shared types and constants of the free-segment allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package salfp_pkg;

   localparam int SEGMENTS  = 16;
   localparam int ADDR_BITS = 16;
   localparam int IDX_W     = $clog2(SEGMENTS);
   localparam int SIZE_W    = ADDR_BITS + 1;
   localparam int SUM_W     = ADDR_BITS + 2;

   localparam logic [SIZE_W-1:0] MEM_MAX    = SIZE_W'(1) << ADDR_BITS;
   localparam logic [SIZE_W-1:0] TOTAL_INIT = MEM_MAX;

   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_ZERO  = 2'd3;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_TOTAL  = 1'b1;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PULL,
      OP_PUSH,
      OP_LOAD,
      OP_MARK
   } cell_op_type;

   typedef struct packed {
      logic                 valid;
      logic                 mark;
      logic [ADDR_BITS-1:0] start;
      logic [SIZE_W-1:0]    size;
   } seg_entry_type;

   typedef struct packed {
      logic                 kind;
      logic [ADDR_BITS-1:0] addr;
      logic [SIZE_W-1:0]    len;
   } xact_req_type;

   typedef struct packed {
      xact_req_type         req;
      logic                 found;
      logic [IDX_W-1:0]     pick;
      logic [ADDR_BITS-1:0] pstart;
      logic [SIZE_W-1:0]    psize;
      logic [SIZE_W-1:0]    score;
      logic [ADDR_BITS-1:0] mstart;
      logic [SIZE_W-1:0]    msize;
   } scan_res_type;

endpackage

`default_nettype wire

FILE: rtl/salfp_cell.sv
// ---------------------------------------------------------------------------
// salfp_cell
// One table entry; pulls from its right neighbor, pushes from its left.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salfp_cell (
   input  wire                           clock,
   input  wire                           reset,
   input  salfp_pkg::cell_op_type        op,
   input  wire                           sel,
   input  salfp_pkg::seg_entry_type      prev_in,
   input  salfp_pkg::seg_entry_type      next_in,
   input  salfp_pkg::seg_entry_type      init_in,
   output salfp_pkg::seg_entry_type      ent
);

   salfp_pkg::seg_entry_type ent_ff;
   salfp_pkg::seg_entry_type ent_in;

   always_comb begin
      ent_in = ent_ff;
      case (op)
         salfp_pkg::OP_HOLD: ent_in = ent_ff;
         salfp_pkg::OP_PULL: ent_in = sel ? next_in : ent_ff;
         salfp_pkg::OP_PUSH: ent_in = prev_in;
         salfp_pkg::OP_LOAD: ent_in = init_in;
         salfp_pkg::OP_MARK: ent_in.mark = ent_ff.mark | sel;
         default:            ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= init_in;
      end else begin
         ent_ff <= ent_in;
      end
   end

   assign ent = ent_ff;

endmodule

`default_nettype wire

FILE: rtl/salfp_scan.sv
// ---------------------------------------------------------------------------
// salfp_scan
// Fit search and merge tracking over the entry at the head of the chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salfp_scan (
   input  wire                           clock,
   input  wire                           clear,
   input  salfp_pkg::xact_req_type       req_new,
   input  wire                           step,
   input  wire [salfp_pkg::IDX_W-1:0]    idx,
   input  wire [1:0]                     policy,
   input  salfp_pkg::seg_entry_type      head,
   output logic                          head_mark,
   output salfp_pkg::scan_res_type       res
);

   salfp_pkg::scan_res_type res_ff;
   salfp_pkg::scan_res_type res_in;

   logic [salfp_pkg::SUM_W-1:0]  mend;
   logic [salfp_pkg::SUM_W-1:0]  head_end;
   logic [salfp_pkg::SUM_W-1:0]  msum;
   logic [salfp_pkg::SIZE_W-1:0] msat;
   logic [salfp_pkg::SIZE_W-1:0] diff;
   logic                         fits;
   logic                         take;
   logic                         hit_after;
   logic                         hit_before;

   always_comb begin
      mend = {2'b00, res_ff.req.addr} + {1'b0, res_ff.req.len};
      head_end = {2'b00, head.start} + {1'b0, head.size};
      msum = {1'b0, res_ff.msize} + {1'b0, head.size};
      msat = (msum > {1'b0, salfp_pkg::MEM_MAX}) ? salfp_pkg::MEM_MAX
                                                  : msum[salfp_pkg::SIZE_W-1:0];
      fits = head.valid && (head.size >= res_ff.req.len);
      diff = head.size - res_ff.req.len;
      take = !res_ff.found
         || (policy == salfp_pkg::POLICY_BEST  && diff < res_ff.score)
         || (policy == salfp_pkg::POLICY_WORST && diff > res_ff.score);
      hit_after  = {2'b00, head.start} == mend;
      hit_before = head_end == {2'b00, res_ff.mstart};
      head_mark = step && head.valid && (res_ff.req.kind == salfp_pkg::KIND_FREE)
         && (hit_after || hit_before);

      res_in = res_ff;
      if (clear) begin
         res_in.req    = req_new;
         res_in.found  = 1'b0;
         res_in.mstart = req_new.addr;
         res_in.msize  = req_new.len;
      end else if (step) begin
         if (res_ff.req.kind == salfp_pkg::KIND_ALLOC) begin
            if (fits && take) begin
               res_in.found  = 1'b1;
               res_in.pick   = idx;
               res_in.score  = diff;
               res_in.pstart = head.start;
               res_in.psize  = head.size;
            end
         end else if (head_mark) begin
            res_in.msize = msat;
            if (!hit_after) begin
               res_in.mstart = head.start;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

FILE: rtl/segment_allocator_fit_policies.sv
// ---------------------------------------------------------------------------
// segment_allocator_fit_policies
// Free-segment table kept as a chain of cells, first/best/worst fit, merge.
// ---------------------------------------------------------------------------
// Zero length or out-of-memory free answers in the cycle after start.
// No fit or table full answers from the decide state after the scan rotates
// the chain once; other requests go on to compaction, which removes one
// marked entry per cycle and then pushes the new entry with the response.
// A new start is taken only while busy is low; busy is high from the scan until the response.
// Reset: table holds [0, 65536), first fit; rsp_strobe high one cycle, no stall.
`timescale 1ns / 1ps
`default_nettype none

`include "segment_allocator_fit_policies_macros.svh"

module segment_allocator_fit_policies (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire                                req_type,
   input  wire [salfp_pkg::ADDR_BITS-1:0]     req_block_address,
   input  wire [salfp_pkg::SIZE_W-1:0]        req_block_length,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [salfp_pkg::ADDR_BITS-1:0]    rsp_grant_address,
   output logic [salfp_pkg::SIZE_W-1:0]       rsp_grant_length,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire [2:0]                          paddr,
   input  wire [31:0]                         pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int NS = salfp_pkg::SEGMENTS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_COMPACT
   } state_type;

   state_type                        state_ff;
   logic [salfp_pkg::IDX_W-1:0]      cnt_ff;
   logic [1:0]                       policy_ff;
   logic [salfp_pkg::SIZE_W-1:0]     total_ff;
   logic                             rsp_strobe_ff;
   logic [1:0]                       rsp_status_ff;
   logic [salfp_pkg::ADDR_BITS-1:0]  rsp_addr_ff;
   logic [salfp_pkg::SIZE_W-1:0]     rsp_len_ff;

   logic                             accept;
   logic                             wr_en;
   logic                             wr_total;
   logic [salfp_pkg::SIZE_W-1:0]     total_clamp;
   logic [salfp_pkg::SUM_W-1:0]      mend_in;
   salfp_pkg::xact_req_type          req_new;
   salfp_pkg::scan_res_type          res;
   logic                             head_mark;
   logic                             step;
   salfp_pkg::cell_op_type           op;
   salfp_pkg::seg_entry_type         ents [NS];
   salfp_pkg::seg_entry_type         init0;
   salfp_pkg::seg_entry_type         push_ent;
   salfp_pkg::seg_entry_type         last_next;
   salfp_pkg::seg_entry_type         rot_ent;
   logic [NS-1:0]                    sel;
   logic [NS-1:0]                    valid_vec;
   logic [NS-1:0]                    mark_vec;
   logic [NS-1:0]                    prefix;
   logic                             any_mark;
   logic [salfp_pkg::SIZE_W-1:0]     rest;
   logic                             need_push;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign wr_total = wr_en && (paddr[2] == salfp_pkg::REG_TOTAL);
   assign prdata  = (paddr[2] == salfp_pkg::REG_TOTAL)
                  ? {{(32 - salfp_pkg::SIZE_W){1'b0}}, total_ff}
                  : {30'd0, policy_ff};

   always_comb begin
      total_clamp = pwdata[salfp_pkg::SIZE_W-1:0];
      if (total_clamp == '0) begin
         total_clamp = salfp_pkg::SIZE_W'(1);
      end else if (total_clamp > salfp_pkg::MEM_MAX) begin
         total_clamp = salfp_pkg::MEM_MAX;
      end
   end

   assign req_new.kind = req_type;
   assign req_new.addr = req_block_address;
   assign req_new.len  = req_block_length;
   assign mend_in = {2'b00, req_block_address} + {1'b0, req_block_length};
   assign step = (state_ff == ST_SCAN);

   salfp_scan u_scan (
      .clock     (clock),
      .clear     (accept),
      .req_new   (req_new),
      .step      (step),
      .idx       (cnt_ff),
      .policy    (policy_ff),
      .head      (ents[0]),
      .head_mark (head_mark),
      .res       (res)
   );

   always_comb begin
      init0.valid = 1'b1;
      init0.mark  = 1'b0;
      init0.start = '0;
      init0.size  = (wr_total && !reset) ? total_clamp : salfp_pkg::TOTAL_INIT;

      rest = res.psize - res.req.len;
      need_push = (res.req.kind == salfp_pkg::KIND_FREE) || (rest != '0);
      push_ent.valid = 1'b1;
      push_ent.mark  = 1'b0;
      if (res.req.kind == salfp_pkg::KIND_FREE) begin
         push_ent.start = res.mstart;
         push_ent.size  = res.msize;
      end else begin
         push_ent.start = salfp_pkg::ADDR_BITS'({1'b0, res.pstart} + res.req.len);
         push_ent.size  = rest;
      end

      rot_ent = ents[0];
      rot_ent.mark = ents[0].mark | head_mark;
      last_next = (state_ff == ST_SCAN) ? rot_ent : '0;

      for (int i = 0; i < NS; i++) begin
         valid_vec[i] = ents[i].valid;
         mark_vec[i]  = ents[i].mark;
      end
      prefix[0] = mark_vec[0];
      for (int i = 1; i < NS; i++) begin
         prefix[i] = prefix[i-1] | mark_vec[i];
      end
      any_mark = prefix[NS-1];

      op  = salfp_pkg::OP_HOLD;
      sel = '0;
      if (wr_total) begin
         op = salfp_pkg::OP_LOAD;
      end else begin
         case (state_ff)
            ST_SCAN: begin
               op  = salfp_pkg::OP_PULL;
               sel = '1;
            end
            ST_DECIDE: begin
               if (res.req.kind == salfp_pkg::KIND_ALLOC && res.found) begin
                  op = salfp_pkg::OP_MARK;
                  for (int i = 0; i < NS; i++) begin
                     sel[i] = (res.pick == salfp_pkg::IDX_W'(i));
                  end
               end
            end
            ST_COMPACT: begin
               if (any_mark) begin
                  op  = salfp_pkg::OP_PULL;
                  sel = prefix;
               end else if (need_push) begin
                  op = salfp_pkg::OP_PUSH;
               end
            end
            default: op = salfp_pkg::OP_HOLD;
         endcase
      end
   end

   for (genvar g = 0; g < NS; g++) begin : g_cell
      salfp_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .op      (op),
         .sel     (sel[g]),
         .prev_in ((g == 0) ? push_ent : ents[(g == 0) ? 0 : g - 1]),
         .next_in ((g == NS - 1) ? last_next : ents[(g == NS - 1) ? g : g + 1]),
         .init_in ((g == 0) ? init0 : salfp_pkg::seg_entry_type'('0)),
         .ent     (ents[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         policy_ff     <= salfp_pkg::POLICY_FIRST;
         total_ff      <= salfp_pkg::TOTAL_INIT;
         rsp_strobe_ff <= 1'b0;
         rsp_status_ff <= salfp_pkg::STATUS_OK;
         rsp_addr_ff   <= '0;
         rsp_len_ff    <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (wr_en) begin
            if (paddr[2] == salfp_pkg::REG_TOTAL) begin
               total_ff <= total_clamp;
            end else begin
               policy_ff <= pwdata[1:0];
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cnt_ff <= '0;
                  if (req_block_length == '0) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_status_ff <= salfp_pkg::STATUS_ZERO;
                     rsp_addr_ff   <= '0;
                     rsp_len_ff    <= '0;
                  end else if (req_type == salfp_pkg::KIND_FREE
                               && mend_in > {1'b0, total_ff}) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_status_ff <= salfp_pkg::STATUS_NOFIT;
                     rsp_addr_ff   <= '0;
                     rsp_len_ff    <= '0;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == salfp_pkg::IDX_W'(NS - 1)) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (res.req.kind == salfp_pkg::KIND_ALLOC && !res.found) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_status_ff <= salfp_pkg::STATUS_NOFIT;
                  rsp_addr_ff   <= '0;
                  rsp_len_ff    <= '0;
                  state_ff      <= ST_IDLE;
               end else if (res.req.kind == salfp_pkg::KIND_FREE
                            && ents[NS-1].valid && !any_mark) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_status_ff <= salfp_pkg::STATUS_FULL;
                  rsp_addr_ff   <= '0;
                  rsp_len_ff    <= '0;
                  state_ff      <= ST_IDLE;
               end else begin
                  state_ff <= ST_COMPACT;
               end
            end
            ST_COMPACT: begin
               if (!any_mark) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_status_ff <= salfp_pkg::STATUS_OK;
                  if (res.req.kind == salfp_pkg::KIND_FREE) begin
                     rsp_addr_ff <= '0;
                     rsp_len_ff  <= res.msize;
                  end else begin
                     rsp_addr_ff <= res.pstart;
                     rsp_len_ff  <= res.req.len;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_grant_address = rsp_addr_ff;
   assign rsp_grant_length  = rsp_len_ff;

   `SALFP_ASSERT(a_valid_packed, step || ((valid_vec & (valid_vec + 1'b1)) == '0), "valid entries not packed")
   `SALFP_ASSERT(a_mark_valid, (mark_vec & ~valid_vec) == '0, "mark on empty entry")
   `SALFP_ASSERT_NEXT(a_accept_progress, accept, busy || rsp_strobe, "accepted transaction lost")

endmodule

`default_nettype wire

FILE: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the free-segment allocator: a directed table, then
// random allocate/free traffic across fit policies and memory sizes, each
// transaction checked against a behavioral model of the segment table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

   localparam int ADDR_BITS = salfp_pkg::ADDR_BITS;
   localparam int SIZE_W    = salfp_pkg::SIZE_W;
   localparam int NSEG      = salfp_pkg::SEGMENTS;
   localparam int MEM_CELLS = 1 << ADDR_BITS;
   localparam int SETTLE    = 48;
   localparam int WD_LIMIT  = 4000;

   typedef enum logic [2:0] {
      ROW_ALLOC,
      ROW_FREE,
      ROW_POLICY,
      ROW_TOTAL
   } row_op_type;

   typedef struct {
      logic [1:0]           status;
      logic [ADDR_BITS-1:0] addr;
      logic [SIZE_W-1:0]    len;
   } grant_type;

   typedef struct {
      row_op_type           op;
      logic [ADDR_BITS-1:0] addr;
      logic [SIZE_W-1:0]    len;
      bit                   typed;
      grant_type            want;
   } row_type;

   typedef struct {
      int base;
      int len;
   } range_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_type;
   logic [ADDR_BITS-1:0] req_block_address;
   logic [SIZE_W-1:0]    req_block_length;
   logic                 rsp_strobe;
   logic [1:0]           rsp_status;
   logic [ADDR_BITS-1:0] rsp_grant_address;
   logic [SIZE_W-1:0]    rsp_grant_length;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [2:0]           paddr;
   logic [31:0]          pwdata;
   logic [31:0]          prdata;
   logic                 pready;

   segment_allocator_fit_policies dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_block_address(req_block_address),
      .req_block_length(req_block_length), .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status), .rsp_grant_address(rsp_grant_address),
      .rsp_grant_length(rsp_grant_length), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready)
   );

   // segment table mirror
   int         free_start [NSEG];
   int         free_size  [NSEG];
   int         free_count;
   logic [1:0] cur_policy;
   int         cur_total;

   grant_type  grants_due[$];
   range_type  live_ranges[$];
   row_type    rows[$];
   int         mismatches;
   int         n_xact;
   int         n_rsp;
   int         n_full;
   int         n_nofit;
   int         idle_pct;
   int         stall_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void table_reinit();
      for (int i = 0; i < NSEG; i++) begin
         free_start[i] = 0;
         free_size[i]  = 0;
      end
      free_size[0] = cur_total;
      free_count   = 1;
   endfunction

   function automatic void table_drop(int idx);
      for (int i = idx; i + 1 < free_count; i++) begin
         free_start[i] = free_start[i + 1];
         free_size[i]  = free_size[i + 1];
      end
      free_count--;
      free_start[free_count] = 0;
      free_size[free_count]  = 0;
   endfunction

   function automatic void table_push_front(int base, int len);
      for (int i = free_count; i > 0; i--) begin
         free_start[i] = free_start[i - 1];
         free_size[i]  = free_size[i - 1];
      end
      free_start[0] = base;
      free_size[0]  = len;
      free_count++;
   endfunction

   function automatic grant_type allocate_or_free(logic kind, logic [ADDR_BITS-1:0] a,
                                                  logic [SIZE_W-1:0] l);
      grant_type g;
      bit        found;
      int        pick;
      int        score;
      int        diff;
      int        base;
      int        rest;
      int        mstart;
      int        msize;
      int        mend;
      int        keep;
      int        ks [NSEG];
      int        kz [NSEG];
      g = '{salfp_pkg::STATUS_OK, '0, '0};
      found = 0;
      pick = 0;
      score = 0;
      keep = 0;
      if (l == 0) begin
         g.status = salfp_pkg::STATUS_ZERO;
         return g;
      end
      if (kind == salfp_pkg::KIND_ALLOC) begin
         for (int i = 0; i < free_count; i++) begin
            if (free_size[i] < int'(l)) continue;
            diff = free_size[i] - int'(l);
            if (!found) begin
               found = 1;
               pick  = i;
               score = diff;
               if (cur_policy != salfp_pkg::POLICY_BEST
                   && cur_policy != salfp_pkg::POLICY_WORST) break;
            end else if (cur_policy == salfp_pkg::POLICY_BEST && diff < score) begin
               pick  = i;
               score = diff;
            end else if (cur_policy == salfp_pkg::POLICY_WORST && diff > score) begin
               pick  = i;
               score = diff;
            end
         end
         if (!found) begin
            g.status = salfp_pkg::STATUS_NOFIT;
            return g;
         end
         base = free_start[pick];
         rest = free_size[pick] - int'(l);
         table_drop(pick);
         if (rest != 0) table_push_front(base + int'(l), rest);
         g.addr = base[ADDR_BITS-1:0];
         g.len  = l;
         return g;
      end
      mstart = int'(a);
      msize  = int'(l);
      mend   = int'(a) + int'(l);
      if (mend > cur_total) begin
         g.status = salfp_pkg::STATUS_NOFIT;
         return g;
      end
      for (int i = 0; i < free_count; i++) begin
         if (free_start[i] == mend) begin
            msize += free_size[i];
         end else if (free_start[i] + free_size[i] == mstart) begin
            mstart = free_start[i];
            msize += free_size[i];
         end else begin
            ks[keep] = free_start[i];
            kz[keep] = free_size[i];
            keep++;
            continue;
         end
         if (msize > MEM_CELLS) msize = MEM_CELLS;
      end
      if (keep >= NSEG) begin
         g.status = salfp_pkg::STATUS_FULL;
         return g;
      end
      for (int i = 0; i < NSEG; i++) begin
         free_start[i] = i < keep ? ks[i] : 0;
         free_size[i]  = i < keep ? kz[i] : 0;
      end
      free_count = keep;
      table_push_front(mstart, msize);
      g.len = msize[SIZE_W-1:0];
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type exp_g;
      if (!reset && rsp_strobe) begin
         n_rsp <= n_rsp + 1;
         if (grants_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result status=%0d addr=%0h len=%0h",
                        rsp_status, rsp_grant_address, rsp_grant_length);
         end else begin
            exp_g = grants_due.pop_front();
            if (rsp_status !== exp_g.status || rsp_grant_address !== exp_g.addr ||
                rsp_grant_length !== exp_g.len) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: expected status=%0d addr=%0h len=%0h, got %0d %0h %0h",
                           exp_g.status, exp_g.addr, exp_g.len,
                           rsp_status, rsp_grant_address, rsp_grant_length);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || psel) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= WD_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic issue(input logic kind, input logic [ADDR_BITS-1:0] a,
                        input logic [SIZE_W-1:0] l, input bit last,
                        output grant_type g);
      int gap;
      gap = 0;
      start             <= 1'b1;
      req_type          <= kind;
      req_block_address <= a;
      req_block_length  <= l;
      do @(posedge clock); while (busy);
      g = allocate_or_free(kind, a, l);
      grants_due.push_back(g);
      n_xact++;
      if (g.status == salfp_pkg::STATUS_FULL) n_full++;
      if (g.status == salfp_pkg::STATUS_NOFIT) n_nofit++;
      if (last || $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do begin
            @(posedge clock);
            gap++;
         end while ($urandom_range(99) < idle_pct && gap < 60);
      end
   endtask

   task automatic drain();
      while (grants_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_idx, input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_idx == salfp_pkg::REG_POLICY) begin
         cur_policy = value[1:0];
      end else begin
         cur_total = value & 32'h1FFFF;
         if (cur_total == 0) cur_total = 1;
         if (cur_total > MEM_CELLS) cur_total = MEM_CELLS;
         table_reinit();
         live_ranges.delete();
      end
      @(posedge clock);
   endtask

   function automatic void add_row(row_op_type op, int a, int l, bit typed,
                                   logic [1:0] st, int ga, int gl);
      row_type r;
      r.op    = op;
      r.addr  = a[ADDR_BITS-1:0];
      r.len   = l[SIZE_W-1:0];
      r.typed = typed;
      r.want  = '{st, ga[ADDR_BITS-1:0], gl[SIZE_W-1:0]};
      rows.push_back(r);
   endfunction

   task automatic random_phase(int policy, int total, int pct, int count);
      grant_type g;
      range_type rg;
      int        r;
      int        idx;
      int        l;
      int        a;
      drain();
      csr_write(salfp_pkg::REG_POLICY, policy);
      csr_write(salfp_pkg::REG_TOTAL, total);
      idle_pct = pct;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 85 && r >= 45 && live_ranges.size() != 0) begin
            idx = $urandom_range(live_ranges.size() - 1);
            rg  = live_ranges[idx];
            live_ranges.delete(idx);
            issue(salfp_pkg::KIND_FREE, rg.base[ADDR_BITS-1:0], rg.len[SIZE_W-1:0],
                  n == count - 1, g);
         end else if (r < 85) begin
            l = (r < 3) ? $urandom_range(1, 17'h1FFFF)
                        : $urandom_range(1, cur_total / 6 > 1 ? cur_total / 6 : 1);
            issue(salfp_pkg::KIND_ALLOC, ADDR_BITS'($urandom), SIZE_W'(l),
                  n == count - 1, g);
            if (g.status == salfp_pkg::STATUS_OK)
               live_ranges.push_back('{int'(g.addr), int'(g.len)});
         end else begin
            a = (r < 92) ? $urandom : $urandom_range(0, cur_total - 1);
            l = (r == 99) ? 0 : (r < 95 ? $urandom_range(0, 17'h1FFFF)
                                        : $urandom_range(1, 64));
            issue(logic'($urandom_range(1)), ADDR_BITS'(a), SIZE_W'(l), n == count - 1, g);
         end
      end
   endtask

   initial begin
      grant_type g;
      reset             = 1'b1;
      start             = 1'b0;
      req_type          = salfp_pkg::KIND_ALLOC;
      req_block_address = '0;
      req_block_length  = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      mismatches        = 0;
      n_xact            = 0;
      n_rsp             = 0;
      n_full            = 0;
      n_nofit           = 0;
      idle_pct          = 0;
      stall_count       = 0;
      cur_policy        = salfp_pkg::POLICY_FIRST;
      cur_total         = MEM_CELLS;
      table_reinit();

      add_row(ROW_ALLOC, 0,      0,       1, salfp_pkg::STATUS_ZERO,  0, 0);
      add_row(ROW_ALLOC, 0,      65536,   1, salfp_pkg::STATUS_OK,    0, 65536);
      add_row(ROW_ALLOC, 0,      1,       1, salfp_pkg::STATUS_NOFIT, 0, 0);
      add_row(ROW_FREE,  65535,  2,       1, salfp_pkg::STATUS_NOFIT, 0, 0);
      add_row(ROW_FREE,  0,      65536,   1, salfp_pkg::STATUS_OK,    0, 65536);
      add_row(ROW_FREE,  65535,  0,       1, salfp_pkg::STATUS_ZERO,  0, 0);
      add_row(ROW_ALLOC, 0,      100,     0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_ALLOC, 0,      200,     0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_ALLOC, 0,      100,     0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_ALLOC, 0,      300,     0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_FREE,  0,      100,     0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_FREE,  300,    100,     0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_POLICY, 0, salfp_pkg::POLICY_BEST, 0, salfp_pkg::STATUS_OK, 0, 0);
      add_row(ROW_ALLOC, 0,      100,     0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_POLICY, 0, salfp_pkg::POLICY_WORST, 0, salfp_pkg::STATUS_OK, 0, 0);
      add_row(ROW_ALLOC, 0,      60,      0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_POLICY, 0,     3,       0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_ALLOC, 0,      50,      0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_FREE,  100,    200,     0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_FREE,  0,      65535,   0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_POLICY, 0, salfp_pkg::POLICY_WORST, 0, salfp_pkg::STATUS_OK, 0, 0);
      add_row(ROW_TOTAL, 0,      0,       0, salfp_pkg::STATUS_OK,    0, 0);
      add_row(ROW_ALLOC, 0,      1,       1, salfp_pkg::STATUS_OK,    0, 1);
      add_row(ROW_ALLOC, 0,      1,       1, salfp_pkg::STATUS_NOFIT, 0, 0);
      add_row(ROW_TOTAL, 0,      17'h1FFFF, 0, salfp_pkg::STATUS_OK,  0, 0);
      add_row(ROW_ALLOC, 0,      17'h1FFFF, 1, salfp_pkg::STATUS_NOFIT, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].op == ROW_POLICY || rows[i].op == ROW_TOTAL) begin
            drain();
            csr_write(rows[i].op == ROW_POLICY ? salfp_pkg::REG_POLICY
                                               : salfp_pkg::REG_TOTAL,
                      int'(rows[i].len));
         end else begin
            issue(rows[i].op == ROW_FREE ? salfp_pkg::KIND_FREE : salfp_pkg::KIND_ALLOC,
                  rows[i].addr, rows[i].len, 1, g);
            if (rows[i].typed && g != rows[i].want) begin
               mismatches++;
               $display("ERROR: model disagrees with table row %0d", i);
            end
         end
      end

      random_phase(salfp_pkg::POLICY_FIRST, 65536, 0,  140);
      random_phase(salfp_pkg::POLICY_BEST,  4096,  84, 130);
      random_phase(salfp_pkg::POLICY_WORST, 300,   0,  130);
      random_phase(3,                       1000,  28, 130);
      random_phase(salfp_pkg::POLICY_BEST,  64,    84, 130);
      random_phase(salfp_pkg::POLICY_WORST, 65536, 28, 130);
      drain();

      $display("Covered %0d transactions, %0d results, %0d table-full, %0d no-fit",
               n_xact, n_rsp, n_full, n_nofit);
      $display("Policies first/best/worst/code three, memory sizes 1 to 65536");
      if (mismatches == 0 && grants_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
